/* hdl/kpa_pkg.sv */
// ============================================================================
// kpa_pkg: shared types and constants of the key press qualifier
// Command codes, field widths, register reset values and the structs that
// travel between the configuration block, the mark table and the top level.
// ============================================================================
package kpa_pkg;

    localparam int NUM_CODES_DEF = 256;

    localparam int CODE_W  = 8;
    localparam int CFG_W   = 8;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int CNT_W   = 16;
    localparam int MULT_W  = 2;
    localparam int PROD_W  = 2 * CFG_W;
    localparam int THR_W   = PROD_W + 2;
    localparam int SCALE_W = CNT_W + 6;
    localparam int EPOCH_W = 4;
    localparam int MARK_W  = EPOCH_W + 1;

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_REPEAT = 2'd1,
        CMD_ARM    = 2'd2
    } cmd_t;

    localparam logic REG_SPEED = 1'b0;
    localparam logic REG_RATE  = 1'b1;

    localparam logic [CFG_W-1:0] SPEED_RST = 8'd8;
    localparam logic [CFG_W-1:0] RATE_RST  = 8'd60;
    localparam int               PROD_RST  = 8 * 60;

    localparam logic [MULT_W-1:0] MULT_NONE  = 2'd0;
    localparam logic [MULT_W-1:0] MULT_NEXT  = 2'd1;
    localparam logic [MULT_W-1:0] MULT_TWO   = 2'd2;
    localparam logic [MULT_W-1:0] MULT_FIRST = 2'd3;

    typedef struct packed {
        logic [PROD_W-1:0] p1;
        logic [THR_W-1:0]  p3;
    } thr_t;

    typedef struct packed {
        logic arm;
        logic set;
        logic clr;
    } mark_op_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic               held;
    } mark_ent_t;

endpackage

/* hdl/kpa_if.sv */
// ============================================================================
// kpa_if: channel interfaces of the key press qualifier
// Poll channel carrying command, code index and key level, and result
// channel carrying the fire flag, both with a valid/ready handshake.
// ============================================================================
interface kpa_in_if;
    logic                         valid;
    logic                         ready;
    kpa_pkg::cmd_t                command;
    logic [kpa_pkg::CODE_W-1:0]   code_index;
    logic                         key_down;

    modport source (output valid, output command, output code_index,
                    output key_down, input ready);
    modport sink   (input valid, input command, input code_index,
                    input key_down, output ready);
endinterface

interface kpa_out_if;
    logic valid;
    logic ready;
    logic fire;

    modport source (output valid, output fire, input ready);
    modport sink   (input valid, input fire, output ready);
endinterface

/* hdl/kpa_cfg.sv */
// ============================================================================
// kpa_cfg: APB configuration registers
// Holds repeat speed and frame rate and, on each write, the products
// speed*rate and 3*speed*rate used as repeat thresholds.
// ============================================================================
module kpa_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kpa_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpa_pkg::DATA_W-1:0]  pwdata,
    output logic [kpa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output kpa_pkg::thr_t               thr
);
    import kpa_pkg::*;

    logic [CFG_W-1:0]  speed_reg;
    logic [CFG_W-1:0]  rate_reg;
    thr_t              thr_reg;
    logic              wr_en;
    logic [CFG_W-1:0]  op_a;
    logic [CFG_W-1:0]  op_b;
    logic [PROD_W-1:0] prod;
    thr_t              thr_next;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == REG_RATE)
        begin
            op_a = speed_reg;
            op_b = pwdata[CFG_W-1:0];
        end
        else
        begin
            op_a = pwdata[CFG_W-1:0];
            op_b = rate_reg;
        end
        prod        = {{CFG_W{1'b0}}, op_a} * {{CFG_W{1'b0}}, op_b};
        thr_next.p1 = prod;
        thr_next.p3 = {2'b00, prod} + {1'b0, prod, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RST;
            rate_reg   <= RATE_RST;
            thr_reg.p1 <= PROD_W'(PROD_RST);
            thr_reg.p3 <= THR_W'(3 * PROD_RST);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_RATE)
            begin
                rate_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                speed_reg <= pwdata[CFG_W-1:0];
            end
            thr_reg <= thr_next;
        end
    end

    assign prdata = (paddr[2] == REG_RATE) ? {{(DATA_W-CFG_W){1'b0}}, rate_reg}
                                           : {{(DATA_W-CFG_W){1'b0}}, speed_reg};
    assign thr    = thr_reg;

endmodule

/* hdl/kpa_marks.sv */
// ============================================================================
// kpa_marks: storage of the held mark table
// Generic RAM with one write port and one read port whose data is
// registered; width and depth are parameters.
// ============================================================================
module kpa_marks #(
    parameter int WIDTH = kpa_pkg::MARK_W,
    parameter int DEPTH = kpa_pkg::NUM_CODES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/key_press_edge_autorepeat.sv */
// ============================================================================
// key_press_edge_autorepeat: key press qualifier with typematic auto-repeat
// Qualifies polled key levels into press events in edge or repeat mode.
// ============================================================================
// The block takes one poll transaction per clock cycle while the result side
// keeps taking transactions and no rewrite of the mark RAM holds the input
// off. A poll accepted at a rising edge reads its held mark from the mark
// RAM, is evaluated in the following cycle, and its fire result is registered
// into the output stage once that stage is empty or its result is taken. The
// repeat threshold is compared as 60*count > multiple*speed*rate against
// products that are computed when a configuration register is written, so no
// division is needed per poll. Each mark entry carries the arm epoch in which
// it was written, and entries of older epochs read as the global arm state,
// so an arm itself writes nothing to the mark RAM. After reset the block clears
// the mark RAM before it accepts the first poll, and every 2^EPOCH_W-th arm
// (every sixteenth) rewrites the RAM while the input is held off.
module key_press_edge_autorepeat #(
    parameter int NUM_CODES = kpa_pkg::NUM_CODES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    kpa_in_if.sink                      key_in,
    kpa_out_if.source                   fire_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kpa_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpa_pkg::DATA_W-1:0]  pwdata,
    output logic [kpa_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kpa_pkg::*;

    localparam int                 IDX_W      = $clog2(NUM_CODES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_CODES - 1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    thr_t               thr;
    mark_op_t           op;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   ram_waddr;
    logic               ram_we;
    mark_ent_t          wr_ent;
    mark_ent_t          rd_ent;
    logic               mark;
    logic               accept;
    logic               idx_ok;
    logic               s1_adv;
    logic               wrap_arm;
    logic               s1_valid_reg;
    cmd_t               s1_cmd_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_ok_reg;
    logic               s1_down_reg;
    logic               fwd_hit_reg;
    logic               fwd_held_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic               base_reg;
    logic               base_next;
    logic               sweep_reg;
    logic [IDX_W-1:0]   sweep_idx_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   count_inc;
    logic [MULT_W-1:0]  mult_reg;
    logic [MULT_W-1:0]  mult_next;
    logic [SCALE_W-1:0] scaled;
    logic [THR_W-1:0]   limit;
    logic               fire_next;
    logic               out_valid_reg;
    logic               fire_reg;

    kpa_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thr     (thr)
    );

    kpa_marks #(
        .WIDTH (MARK_W),
        .DEPTH (NUM_CODES)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_ent),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (rd_ent)
    );

    assign s1_adv       = s1_valid_reg && (!out_valid_reg || fire_out.ready);
    assign wrap_arm     = s1_valid_reg && (s1_cmd_reg == CMD_ARM) && (epoch_reg == EPOCH_LAST);
    assign key_in.ready = !sweep_reg && !wrap_arm && (!s1_valid_reg || s1_adv);
    assign accept       = key_in.valid && key_in.ready;
    assign rd_idx       = IDX_W'(key_in.code_index);
    assign idx_ok       = 32'(key_in.code_index) < NUM_CODES;
    assign mark         = fwd_hit_reg ? fwd_held_reg
                        : ((rd_ent.tag == epoch_reg) ? rd_ent.held : base_reg);
    assign ram_we       = sweep_reg || op.set || op.clr;
    assign ram_waddr    = sweep_reg ? sweep_idx_reg : s1_idx_reg;
    assign wr_ent       = {epoch_reg, (sweep_reg ? base_reg : op.set)};
    assign count_inc    = count_reg + 1'b1;
    assign scaled       = {count_inc, 6'b0} - {4'b0, count_inc, 2'b0};

    always_comb
    begin
        unique case (mult_reg)
            MULT_NONE:  limit = '0;
            MULT_NEXT:  limit = {2'b00, thr.p1};
            MULT_TWO:   limit = {1'b0, thr.p1, 1'b0};
            MULT_FIRST: limit = thr.p3;
            default:    limit = '0;
        endcase
    end

    always_comb
    begin
        op         = '0;
        fire_next  = 1'b0;
        count_next = count_reg;
        mult_next  = mult_reg;
        epoch_next = epoch_reg;
        base_next  = base_reg;
        if (s1_adv)
        begin
            unique case (s1_cmd_reg)
                CMD_ARM:
                begin
                    op.arm     = 1'b1;
                    epoch_next = epoch_reg + 1'b1;
                    base_next  = 1'b1;
                end
                CMD_EDGE, CMD_REPEAT:
                begin
                    if (s1_ok_reg)
                    begin
                        if (!s1_down_reg)
                        begin
                            op.clr = 1'b1;
                        end
                        else if (!mark)
                        begin
                            op.set    = 1'b1;
                            fire_next = 1'b1;
                            if (s1_cmd_reg == CMD_REPEAT)
                            begin
                                mult_next  = MULT_FIRST;
                                count_next = '0;
                            end
                        end
                        else if (s1_cmd_reg == CMD_REPEAT)
                        begin
                            count_next = count_inc;
                            if (scaled > {{(SCALE_W-THR_W){1'b0}}, limit})
                            begin
                                mult_next  = MULT_NEXT;
                                count_next = '0;
                                fire_next  = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            mult_reg      <= MULT_NONE;
            epoch_reg     <= '0;
            base_reg      <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            mult_reg  <= mult_next;
            epoch_reg <= epoch_next;
            base_reg  <= base_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (fire_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (sweep_reg)
            begin
                sweep_idx_reg <= sweep_idx_reg + 1'b1;
                if (sweep_idx_reg == LAST_IDX)
                begin
                    sweep_reg <= 1'b0;
                end
            end
            else if (op.arm && (epoch_reg == EPOCH_LAST))
            begin
                sweep_reg     <= 1'b1;
                sweep_idx_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= key_in.command;
            s1_idx_reg   <= rd_idx;
            s1_ok_reg    <= idx_ok;
            s1_down_reg  <= key_in.key_down;
            fwd_hit_reg  <= ram_we && (ram_waddr == rd_idx);
            fwd_held_reg <= wr_ent.held;
        end
        if (s1_adv)
        begin
            fire_reg <= fire_next;
        end
    end

    assign fire_out.valid = out_valid_reg;
    assign fire_out.fire  = fire_reg;

endmodule

/* hdl/kpa_checker.sv */
// ============================================================================
// kpa_checker: port-level checks of the key press qualifier
// Watches the poll and result ports and is bound to the top level.
// ============================================================================
module kpa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [1:0]                 in_command,
    input logic [kpa_pkg::CODE_W-1:0] in_code_index,
    input logic                       in_key_down,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       out_fire
);
    import kpa_pkg::*;

    logic in_acc;
    logic held_poll;
    logic out_free;

    assign in_acc    = in_valid && in_ready;
    assign held_poll = in_acc && in_key_down && in_command == CMD_EDGE;
    assign out_free  = !out_valid || out_ready;

    // A result waiting for the sink keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_fire))
        else $error("result changed while stalled");

    // Every accepted transaction has its result offered on the result port.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> ##1 out_valid)
        else $error("accepted transaction produced no result");

    // Releases, arm and unused commands never fire.
    a_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (!in_key_down || in_command == CMD_ARM || in_command == 2'd3)
        ##1 out_free |=> !out_fire)
        else $error("fire on a transaction that cannot fire");

    // A code held down over two back-to-back edge polls fires at most once.
    a_edge_once: assert property (@(posedge clk) disable iff (!rst_n)
        held_poll && $past(rst_n) && $past(held_poll)
        && $past(in_code_index) == in_code_index
        ##1 out_free |=> !out_fire)
        else $error("edge poll fired on a held key");

endmodule

bind key_press_edge_autorepeat kpa_checker u_kpa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (key_in.valid),
    .in_ready      (key_in.ready),
    .in_command    (key_in.command),
    .in_code_index (key_in.code_index),
    .in_key_down   (key_in.key_down),
    .out_valid     (fire_out.valid),
    .out_ready     (fire_out.ready),
    .out_fire      (fire_out.fire)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top: testbench of the key press qualifier with typematic auto-repeat
// Drives poll transactions with random gaps, writes the speed and rate
// registers between phases, and checks every fire result against a cycle-free
// model of the held marks, the shared repeat counter and the delay multiple.
// ============================================================================
module tb_top;

    import kpa_pkg::*;

    localparam int   STUCK_LIMIT = 5000;
    localparam int   LONG_STALL  = 200;
    localparam cmd_t CMD_UNUSED  = cmd_t'(2'd3);

    localparam logic [ADDR_W-1:0] ADDR_SPEED = {REG_SPEED, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RATE  = {REG_RATE, 2'b00};

    typedef struct {
        cmd_t              cmd;
        logic [CODE_W-1:0] code;
        logic              down;
    } poll_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    kpa_in_if  key_in();
    kpa_out_if fire_out();

    key_press_edge_autorepeat u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_in   (key_in),
        .fire_out (fire_out),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    poll_t poll_q[$];
    logic  fire_exp_q[$];

    logic                 held_mark [NUM_CODES_DEF];
    logic [CNT_W-1:0]     rpt_count;
    logic [MULT_W-1:0]    rpt_mult;
    logic [CFG_W-1:0]     cfg_speed;
    logic [CFG_W-1:0]     cfg_rate;

    logic              in_taken;
    bit                gaps_on;
    int                send_gap;
    int                recv_gap;
    int                stall_left;
    int                stall_req;
    int                stall_done;
    int                stuck_cycles;
    int                err_count;
    int                polls_taken;
    int                results_seen;
    int                fires_seen;
    int                settings_run;
    logic [CODE_W-1:0] code_pool [4];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic qualify_press(input poll_t p);
        int   thr;
        logic fire;
        fire = 1'b0;
        if (p.cmd == CMD_ARM) begin
            foreach (held_mark[i])
                held_mark[i] = 1'b1;
        end else if (p.cmd == CMD_EDGE || p.cmd == CMD_REPEAT) begin
            if (!p.down) begin
                held_mark[p.code] = 1'b0;
            end else if (!held_mark[p.code]) begin
                held_mark[p.code] = 1'b1;
                fire = 1'b1;
                if (p.cmd == CMD_REPEAT) begin
                    rpt_mult  = MULT_FIRST;
                    rpt_count = '0;
                end
            end else if (p.cmd == CMD_REPEAT) begin
                rpt_count = rpt_count + 1'b1;
                thr = (int'(rpt_mult) * int'(cfg_speed) * int'(cfg_rate)) / 60;
                if (int'(rpt_count) > thr) begin
                    rpt_mult  = MULT_NEXT;
                    rpt_count = '0;
                    fire      = 1'b1;
                end
            end
        end
        return fire;
    endfunction

    // Result check first, then the prediction of the poll taken at this edge.
    always @(posedge clk)
    begin
        poll_t p;
        logic  exp_fire;
        if (rst_n) begin
            in_taken <= key_in.valid && key_in.ready;
            if (fire_out.valid && fire_out.ready) begin
                results_seen <= results_seen + 1;
                if (fire_out.fire === 1'b1)
                    fires_seen <= fires_seen + 1;
                if (fire_exp_q.size() == 0) begin
                    $error("fire: unexpected transaction, actual %b", fire_out.fire);
                    err_count <= err_count + 1;
                end else begin
                    exp_fire = fire_exp_q.pop_front();
                    if (fire_out.fire !== exp_fire) begin
                        $error("fire: expected %b, actual %b", exp_fire, fire_out.fire);
                        err_count <= err_count + 1;
                    end
                end
            end
            if (key_in.valid && key_in.ready) begin
                p.cmd  = key_in.command;
                p.code = key_in.code_index;
                p.down = key_in.key_down;
                fire_exp_q.push_back(qualify_press(p));
                polls_taken <= polls_taken + 1;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        poll_t p;
        if (!rst_n) begin
            key_in.valid <= 1'b0;
        end else if (!key_in.valid || in_taken) begin
            if (send_gap > 0) begin
                send_gap     <= send_gap - 1;
                key_in.valid <= 1'b0;
            end else if (poll_q.size() > 0) begin
                p = poll_q.pop_front();
                key_in.command    <= p.cmd;
                key_in.code_index <= p.code;
                key_in.key_down   <= p.down;
                key_in.valid      <= 1'b1;
                send_gap          <= pick_gap();
            end else begin
                key_in.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n) begin
            fire_out.ready <= 1'b0;
        end else if (stall_done != stall_req) begin
            stall_left     <= LONG_STALL;
            stall_done     <= stall_done + 1;
            fire_out.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left     <= stall_left - 1;
            fire_out.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap       <= recv_gap - 1;
            fire_out.ready <= 1'b0;
        end else begin
            fire_out.ready <= 1'b1;
            recv_gap       <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((key_in.valid && key_in.ready) || (fire_out.valid && fire_out.ready) || psel)
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void queue_poll(input cmd_t c, input logic [CODE_W-1:0] code,
                                       input logic down);
        poll_t p;
        p.cmd  = c;
        p.code = code;
        p.down = down;
        poll_q.push_back(p);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        if ($urandom_range(0, 9) < 7)
            return code_pool[$urandom_range(0, 3)];
        return CODE_W'($urandom_range(0, NUM_CODES_DEF - 1));
    endfunction

    function automatic cmd_t pick_poll_cmd();
        return $urandom_range(0, 1) ? CMD_REPEAT : CMD_EDGE;
    endfunction

    // A press, a run of held repeat polls long enough to cross the repeat
    // thresholds where that is practical, and a release, with stray polls.
    function automatic int queue_held_key(input logic [CODE_W-1:0] code);
        int thr_first;
        int thr_next;
        int holds;
        int added;
        thr_first = (3 * int'(cfg_speed) * int'(cfg_rate)) / 60;
        thr_next  = (int'(cfg_speed) * int'(cfg_rate)) / 60;
        if (thr_first < 60)
            holds = thr_first + 1 + $urandom_range(0, 2 * (thr_next + 1));
        else
            holds = $urandom_range(1, 12);
        if (holds > 80)
            holds = 80;
        queue_poll(CMD_REPEAT, code, 1'b1);
        added = 1;
        for (int i = 0; i < holds; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_poll(CMD_EDGE, pick_code(), 1'($urandom_range(0, 1)));
                added++;
            end
            queue_poll(CMD_REPEAT, code, 1'b1);
            added++;
        end
        queue_poll(pick_poll_cmd(), code, 1'b0);
        return added + 1;
    endfunction

    task automatic queue_random_polls(input int count);
        int added;
        int r;
        added = 0;
        foreach (code_pool[i])
            code_pool[i] = CODE_W'($urandom_range(0, NUM_CODES_DEF - 1));
        while (added < count) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                added += queue_held_key(pick_code());
            end else begin
                if (r < 72)
                    queue_poll(CMD_EDGE, pick_code(), 1'($urandom_range(0, 1)));
                else if (r < 86)
                    queue_poll(CMD_REPEAT, pick_code(), 1'($urandom_range(0, 1)));
                else if (r < 93)
                    queue_poll(CMD_ARM, CODE_W'($urandom), 1'($urandom_range(0, 1)));
                else
                    queue_poll(CMD_UNUSED, CODE_W'($urandom), 1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        while (poll_q.size() != 0 || key_in.valid || fire_exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        logic [DATA_W-1:0] junk;
        junk = $urandom;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {junk[DATA_W-1:CFG_W], val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SPEED)
            cfg_speed = val;
        else
            cfg_rate = val;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] speed, input logic [CFG_W-1:0] rate,
                             input int count, input bit gaps, input bit long_hold);
        wait_idle();
        write_reg(ADDR_SPEED, speed);
        write_reg(ADDR_RATE, rate);
        settings_run++;
        @(posedge clk);
        gaps_on = gaps;
        if (long_hold)
            stall_req++;
        queue_random_polls(count);
        wait_idle();
    endtask

    initial
    begin
        foreach (held_mark[i])
            held_mark[i] = 1'b0;
        rpt_count         = '0;
        rpt_mult          = MULT_NONE;
        cfg_speed         = SPEED_RST;
        cfg_rate          = RATE_RST;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        key_in.valid      = 1'b0;
        key_in.command    = CMD_EDGE;
        key_in.code_index = '0;
        key_in.key_down   = 1'b0;
        fire_out.ready    = 1'b0;
        gaps_on           = 1'b1;
        send_gap          = 0;
        recv_gap          = 0;
        stall_left        = 0;
        stall_req         = 0;
        stall_done        = 0;
        stuck_cycles      = 0;
        err_count         = 0;
        polls_taken       = 0;
        results_seen      = 0;
        fires_seen        = 0;
        settings_run      = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        @(posedge clk);
        queue_poll(CMD_EDGE, 8'h00, 1'b1);
        queue_poll(CMD_EDGE, 8'h00, 1'b1);
        queue_poll(CMD_REPEAT, 8'h00, 1'b1);
        queue_poll(CMD_EDGE, 8'h00, 1'b0);
        queue_poll(CMD_UNUSED, 8'hFF, 1'b1);
        queue_poll(CMD_EDGE, 8'hFF, 1'b0);
        queue_poll(CMD_ARM, 8'h5A, 1'b0);
        queue_poll(CMD_REPEAT, 8'h07, 1'b1);
        queue_poll(CMD_REPEAT, 8'h07, 1'b1);
        queue_poll(CMD_EDGE, 8'hFF, 1'b1);
        queue_poll(CMD_REPEAT, 8'hFF, 1'b0);
        queue_poll(CMD_REPEAT, 8'hFF, 1'b1);
        queue_poll(CMD_EDGE, 8'hAA, 1'b1);
        queue_poll(CMD_ARM, 8'hFF, 1'b1);
        queue_poll(CMD_EDGE, 8'h55, 1'b1);
        queue_poll(CMD_REPEAT, 8'h55, 1'b0);
        queue_poll(CMD_UNUSED, 8'h00, 1'b0);
        queue_poll(CMD_EDGE, 8'hAA, 1'b0);
        queue_poll(CMD_REPEAT, 8'hAA, 1'b1);
        wait_idle();

        run_phase(8'd0, 8'd1, 85, 1'b1, 1'b0);
        run_phase(8'd255, 8'd1, 85, 1'b0, 1'b1);
        run_phase(8'd1, 8'd255, 85, 1'b1, 1'b0);
        run_phase(8'd255, 8'd255, 40, 1'b1, 1'b0);
        run_phase(CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 255)), 85,
                  1'b1, 1'b0);
        run_phase(SPEED_RST, RATE_RST, 85, 1'b1, 1'b0);
        repeat (10) @(posedge clk);

        $display("Run covered %0d poll transactions and %0d results, %0d of them press events,",
                 polls_taken, results_seen, fires_seen);
        $display("over %0d register settings including both extremes of each register.",
                 settings_run);
        if (err_count == 0 && fire_exp_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
